// ===== rtl/core/linear_probe_hash_table_unit_macros.svh =====
// Assertion macros shared by the hash table unit.
// Simulation builds get the checks; synthesis builds see empty bodies.
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Check that is switched off while reset is high.
`define LPHT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds while reset is high.
`define LPHT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LPHT_ASSERT(lbl, clk, rst, prop, msg)
`define LPHT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/core/lpht_pkg.sv =====
package lpht_pkg;

   // Table geometry
   localparam int TABLE_SIZE = 1024;
   localparam int ADDR_W     = $clog2(TABLE_SIZE);
   localparam int PTR_W      = $clog2(TABLE_SIZE + 1);
   localparam int CNT_W      = PTR_W;

   // Item field widths
   localparam int KEY_W      = 30;
   localparam int GRADE_W    = 3;
   localparam int HANDLE_W   = 32;
   localparam int STATUS_W   = 2;
   localparam int SLOT_W     = 10;
   localparam int ENTRY_W    = 11;

   // Hash: nine zero-padded decimal digits, ASCII codes summed
   localparam int KEY_DIGITS = 9;
   localparam int DCNT_W     = $clog2(KEY_DIGITS);
   localparam int ASCII_ZERO = 48;
   localparam int SUM_W      = $clog2(KEY_DIGITS * (ASCII_ZERO + 9) + 1);
   localparam logic [KEY_W-1:0] NINE_DIGIT_MOD = KEY_W'(1000000000);

   // Divide by ten: multiply by reciprocal, exact for any 32-bit value
   localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;
   localparam int          PROD_W      = KEY_W + 32;

   // Commands
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 2'd0,
      ST_FOUND     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // One table slot as stored in memory
   typedef struct packed {
      logic                valid;
      logic [KEY_W-1:0]    id;
      logic [GRADE_W-1:0]  grade;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   // Hash unit answer
   typedef struct packed {
      logic              done;
      logic [ADDR_W-1:0] home;
   } hash_rsp_type;

endpackage

// ===== rtl/core/lpht_store.sv =====
module lpht_store import lpht_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_data
);

   entry_type mem_ff [TABLE_SIZE];
   entry_type rd_data_ff;

   // Single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/lpht_hash.sv =====
`include "linear_probe_hash_table_unit_macros.svh"

module lpht_hash import lpht_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [KEY_W-1:0] key,
   output hash_rsp_type     hash_rsp
);

   typedef enum logic [1:0] {
      H_IDLE,
      H_DIGIT,
      H_MOD
   } hstate_type;

   hstate_type        state_ff, state_in;
   logic [KEY_W-1:0]  val_ff, val_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;

   logic [PROD_W-1:0] prod_w;
   logic [KEY_W-1:0]  quot_w;
   logic [KEY_W-1:0]  rem_w;
   logic [3:0]        digit_w;
   logic              fits_w;

   // Shared divide-by-ten unit: one digit per cycle
   assign prod_w  = PROD_W'(val_ff) * PROD_W'(RECIP_10);
   assign quot_w  = KEY_W'(prod_w >> RECIP_SHIFT);
   assign rem_w   = val_ff - ((quot_w << 3) + (quot_w << 1));
   assign digit_w = rem_w[3:0];

   // Sum already below table size
   assign fits_w = 32'(sum_ff) < 32'(TABLE_SIZE);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      val_in   = val_ff;
      sum_in   = sum_ff;
      dcnt_in  = dcnt_ff;
      case (state_ff)
         H_IDLE: begin
            if (start) begin
               // keep the nine low-order digits
               val_in   = (key >= NINE_DIGIT_MOD) ? key - NINE_DIGIT_MOD : key;
               sum_in   = '0;
               dcnt_in  = '0;
               state_in = H_DIGIT;
            end
         end
         H_DIGIT: begin
            sum_in = sum_ff + SUM_W'(ASCII_ZERO) + SUM_W'(digit_w);
            val_in = quot_w;
            if (dcnt_ff == DCNT_W'(KEY_DIGITS - 1)) begin
               state_in = H_MOD;
            end else begin
               dcnt_in = dcnt_ff + DCNT_W'(1);
            end
         end
         H_MOD: begin
            if (fits_w) begin
               state_in = H_IDLE;
            end else begin
               sum_in = sum_ff - SUM_W'(TABLE_SIZE);
            end
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
      end else begin
         state_ff <= state_in;
         val_ff   <= val_in;
         sum_ff   <= sum_in;
         dcnt_ff  <= dcnt_in;
      end
   end

   assign hash_rsp.done = (state_ff == H_MOD) && fits_w;
   assign hash_rsp.home = ADDR_W'(sum_ff);

   `LPHT_ASSERT(a_digit_range, clock, reset, (state_ff == H_DIGIT) |-> (digit_w <= 4'd9), "digit above nine")
   `LPHT_ASSERT(a_val_range, clock, reset, (state_ff == H_DIGIT) |-> (val_ff < NINE_DIGIT_MOD), "value above nine digits")
   `LPHT_ASSERT(a_start_idle, clock, reset, start |-> (state_ff == H_IDLE), "hash started while busy")

endmodule

// ===== rtl/core/linear_probe_hash_table_unit.sv =====
// Record table with open addressing and linear probing, one item at a time.
// After reset the unit sweeps the table to mark every slot empty, one slot
// per cycle, and takes no item until the sweep is done. An item is then
// accepted, its nine decimal digits pass through the shared divide-by-ten
// unit (one decimal digit per cycle), the sum is reduced to a slot, and
// each probed slot takes a read and a check on the slot memory (one write
// port, one registered read port). An insert or search that runs off the
// table's end takes one more step, with no read. The result is posted once
// the output register is free; a finished result waits there, and the
// next item is accepted while it waits.
`include "linear_probe_hash_table_unit_macros.svh"

module linear_probe_hash_table_unit import lpht_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_command,
   input  logic [KEY_W-1:0]    req_key_id,
   input  logic [GRADE_W-1:0]  req_grade,
   input  logic [HANDLE_W-1:0] req_record_handle,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic [KEY_W-1:0]    rsp_found_id,
   output logic [GRADE_W-1:0]  rsp_found_grade,
   output logic [HANDLE_W-1:0] rsp_found_handle,
   output logic [ENTRY_W-1:0]  rsp_entry_count
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_PROBE_RD,
      S_PROBE_CHK,
      S_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   clr_ptr_ff, clr_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PTR_W-1:0]    probe_ff, probe_in;

   // latched item
   logic                cmd_ff, cmd_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [GRADE_W-1:0]  grade_ff, grade_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;

   // result under construction
   status_type          res_status_ff, res_status_in;
   logic [ADDR_W-1:0]   res_slot_ff, res_slot_in;
   entry_type           res_entry_ff, res_entry_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]   rsp_slot_ff, rsp_slot_in;
   entry_type           rsp_entry_ff, rsp_entry_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;

   // memory and hash hookup
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   entry_type           wr_data;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   entry_type           rd_data;
   logic                hash_start;
   hash_rsp_type        hash_rsp;

   lpht_hash u_hash (
      .clock    (clock),
      .reset    (reset),
      .start    (hash_start),
      .key      (req_key_id),
      .hash_rsp (hash_rsp)
   );

   lpht_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_addr = probe_ff[ADDR_W-1:0];

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      clr_ptr_in    = clr_ptr_ff;
      count_in      = count_ff;
      probe_in      = probe_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      grade_in      = grade_ff;
      handle_in     = handle_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_entry_in  = res_entry_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = probe_ff[ADDR_W-1:0];
      wr_data       = '0;
      rd_en         = 1'b0;
      hash_start    = 1'b0;

      case (state_ff)
         // mark every slot empty after reset
         S_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_ptr_ff;
            clr_ptr_in = clr_ptr_ff + ADDR_W'(1);
            if (clr_ptr_ff == ADDR_W'(TABLE_SIZE - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_command;
               key_in        = req_key_id;
               grade_in      = req_grade;
               handle_in     = req_record_handle;
               res_status_in = ST_NOT_FOUND;
               res_slot_in   = '0;
               res_entry_in  = '0;
               hash_start    = 1'b1;
               state_in      = S_HASH;
            end
         end
         S_HASH: begin
            if (hash_rsp.done) begin
               probe_in = PTR_W'(hash_rsp.home);
               state_in = S_PROBE_RD;
            end
         end
         // stop at the end of the table, no wrap
         S_PROBE_RD: begin
            if (probe_ff == PTR_W'(TABLE_SIZE)) begin
               res_status_in = (cmd_ff == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
               state_in      = S_FINISH;
            end else begin
               rd_en    = 1'b1;
               state_in = S_PROBE_CHK;
            end
         end
         S_PROBE_CHK: begin
            if (cmd_ff == CMD_INSERT) begin
               if (!rd_data.valid) begin
                  wr_en          = 1'b1;
                  wr_data.valid  = 1'b1;
                  wr_data.id     = key_ff;
                  wr_data.grade  = grade_ff;
                  wr_data.handle = handle_ff;
                  count_in       = count_ff + CNT_W'(1);
                  res_status_in  = ST_INSERTED;
                  res_slot_in    = probe_ff[ADDR_W-1:0];
                  state_in       = S_FINISH;
               end else begin
                  probe_in = probe_ff + PTR_W'(1);
                  state_in = S_PROBE_RD;
               end
            end else begin
               if (!rd_data.valid) begin
                  res_status_in = ST_NOT_FOUND;
                  state_in      = S_FINISH;
               end else if (rd_data.id == key_ff) begin
                  res_status_in = ST_FOUND;
                  res_slot_in   = probe_ff[ADDR_W-1:0];
                  res_entry_in  = rd_data;
                  state_in      = S_FINISH;
               end else begin
                  probe_in = probe_ff + PTR_W'(1);
                  state_in = S_PROBE_RD;
               end
            end
         end
         // post the result once the output register is free
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_entry_in  = res_entry_ff;
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ptr_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ptr_ff    <= clr_ptr_in;
         count_ff      <= count_in;
         probe_ff      <= probe_in;
         cmd_ff        <= cmd_in;
         key_ff        <= key_in;
         grade_ff      <= grade_in;
         handle_ff     <= handle_in;
         res_status_ff <= res_status_in;
         res_slot_ff   <= res_slot_in;
         res_entry_ff  <= res_entry_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_entry_ff  <= rsp_entry_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   // Ports
   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot         = SLOT_W'(rsp_slot_ff);
   assign rsp_found_id     = rsp_entry_ff.id;
   assign rsp_found_grade  = rsp_entry_ff.grade;
   assign rsp_found_handle = rsp_entry_ff.handle;
   assign rsp_entry_count  = ENTRY_W'(rsp_count_ff);

   `LPHT_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(TABLE_SIZE), "occupied count above table size")
   `LPHT_ASSERT(a_count_step, clock, reset, (!$past(reset) && !$stable(count_ff)) |-> (($past(state_ff) == S_PROBE_CHK) && (count_ff == $past(count_ff) + CNT_W'(1))), "occupied count moved outside an insert")
   `LPHT_ASSERT(a_rsp_from_finish, clock, reset, (!$past(reset) && $rose(rsp_valid_ff)) |-> ($past(state_ff) == S_FINISH), "response raised outside finish")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import lpht_pkg::*;

   // Expected answer for one item
   typedef struct {
      status_type          status;
      bit [SLOT_W-1:0]     slot;
      bit [KEY_W-1:0]      id;
      bit [GRADE_W-1:0]    grade;
      bit [HANDLE_W-1:0]   handle;
      bit [ENTRY_W-1:0]    count;
   } table_answer_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_command = CMD_INSERT;
   logic [KEY_W-1:0]    req_key_id = '0;
   logic [GRADE_W-1:0]  req_grade = '0;
   logic [HANDLE_W-1:0] req_record_handle = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [KEY_W-1:0]    rsp_found_id;
   logic [GRADE_W-1:0]  rsp_found_grade;
   logic [HANDLE_W-1:0] rsp_found_handle;
   logic [ENTRY_W-1:0]  rsp_entry_count;

   // Shadow copy of the record table
   bit                  shadow_valid [TABLE_SIZE];
   bit [KEY_W-1:0]      shadow_id [TABLE_SIZE];
   bit [GRADE_W-1:0]    shadow_grade [TABLE_SIZE];
   bit [HANDLE_W-1:0]   shadow_handle [TABLE_SIZE];
   int                  shadow_count = 0;

   table_answer_type    answers_due [$];
   table_answer_type    due;
   bit [KEY_W-1:0]      stored_keys [$];
   int                  status_tally [4];
   int                  mismatch_count = 0;
   int                  results_checked = 0;
   int                  stall_left = 0;
   bit                  idle_on = 1'b1;

   linear_probe_hash_table_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_key_id        (req_key_id),
      .req_grade         (req_grade),
      .req_record_handle (req_record_handle),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_slot          (rsp_slot),
      .rsp_found_id      (rsp_found_id),
      .rsp_found_grade   (rsp_found_grade),
      .rsp_found_handle  (rsp_found_handle),
      .rsp_entry_count   (rsp_entry_count)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Home slot: ASCII digit sum of the nine low-order decimal digits
   function automatic int home_slot_of(bit [KEY_W-1:0] key);
      int unsigned v;
      int          sum;
      v = 32'(key % NINE_DIGIT_MOD);
      sum = 0;
      for (int d = 0; d < KEY_DIGITS; d++) begin
         sum += ASCII_ZERO + (v % 10);
         v = v / 10;
      end
      return sum % TABLE_SIZE;
   endfunction

   // Apply one item to the shadow table and return what the unit should answer
   function automatic table_answer_type table_access(bit cmd, bit [KEY_W-1:0] key,
                                                     bit [GRADE_W-1:0] grade,
                                                     bit [HANDLE_W-1:0] handle);
      table_answer_type a;
      int               p;
      bit               done;
      a.status = ST_NOT_FOUND;
      a.slot   = '0;
      a.id     = '0;
      a.grade  = '0;
      a.handle = '0;
      done     = 1'b0;
      p        = home_slot_of(key);
      if (cmd == CMD_INSERT) begin
         a.status = ST_FULL;
         while (p < TABLE_SIZE && !done) begin
            if (!shadow_valid[p]) begin
               shadow_valid[p]  = 1'b1;
               shadow_id[p]     = key;
               shadow_grade[p]  = grade;
               shadow_handle[p] = handle;
               shadow_count++;
               stored_keys.insert(stored_keys.size(), key);
               a.status = ST_INSERTED;
               a.slot   = SLOT_W'(p);
               done     = 1'b1;
            end else begin
               p++;
            end
         end
      end else begin
         while (p < TABLE_SIZE && !done) begin
            if (!shadow_valid[p]) begin
               done = 1'b1;
            end else if (shadow_id[p] == key) begin
               a.status = ST_FOUND;
               a.slot   = SLOT_W'(p);
               a.id     = shadow_id[p];
               a.grade  = shadow_grade[p];
               a.handle = shadow_handle[p];
               done     = 1'b1;
            end else begin
               p++;
            end
         end
      end
      a.count = ENTRY_W'(shadow_count);
      status_tally[a.status]++;
      return a;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got,
                                  longint unsigned want);
      $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Random idle burst ahead of an item
   task automatic sender_pause();
      int n;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Send one item, wait for it to be taken, queue its expected answer
   task automatic send_item(input bit cmd, input bit [KEY_W-1:0] key,
                            input bit [GRADE_W-1:0] grade,
                            input bit [HANDLE_W-1:0] handle,
                            output table_answer_type ans);
      sender_pause();
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_key_id        <= key;
      req_grade         <= grade;
      req_record_handle <= handle;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ans = table_access(cmd, key, grade, handle);
      answers_due.insert(answers_due.size(), ans);
   endtask

   // Hold off the sender until every answer is back
   task automatic wait_for_answers();
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   function automatic bit [KEY_W-1:0] random_key();
      bit [KEY_W-1:0] k;
      case ($urandom_range(0, 9))
         0:       k = KEY_W'($urandom_range(1000000000, 1073741823));  // above nine digits
         1:       k = KEY_W'($urandom_range(0, 999));                  // mostly zero padding
         default: k = KEY_W'($urandom_range(0, 999999999));
      endcase
      return k;
   endfunction

   // Mix of stored keys, aliases of stored keys and fresh keys
   function automatic bit [KEY_W-1:0] search_key();
      bit [KEY_W-1:0] k;
      int             r;
      r = $urandom_range(0, 9);
      if (stored_keys.size() == 0 || r < 3)
         return random_key();
      k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      // same home slot, different stored value
      if (r < 5 && k < 30'd73741824)
         k = k + 30'd1000000000;
      return k;
   endfunction

   // Edge cases on a nearly empty table
   task automatic test_empty_table();
      table_answer_type ans;
      send_item(CMD_SEARCH, 30'd0, 3'd0, 32'h0, ans);
      send_item(CMD_INSERT, 30'd0, 3'd0, 32'h0, ans);
      send_item(CMD_INSERT, 30'd999999999, 3'd4, 32'hFFFF_FFFF, ans);
      send_item(CMD_INSERT, 30'h3FFF_FFFF, 3'd7, 32'hA5A5_A5A5, ans);
      send_item(CMD_SEARCH, 30'h3FFF_FFFF, 3'd0, 32'h0, ans);
      send_item(CMD_SEARCH, 30'd73741823, 3'd7, 32'hFFFF_FFFF, ans);
      // duplicate key lands one slot up; search still returns the first copy
      send_item(CMD_INSERT, 30'd0, 3'd3, 32'h0000_0001, ans);
      send_item(CMD_SEARCH, 30'd0, 3'd0, 32'h0, ans);
      send_item(CMD_INSERT, 30'd100000000, 3'd2, 32'h5A5A_5A5A, ans);
      send_item(CMD_SEARCH, 30'd100000000, 3'd0, 32'h0, ans);
      send_item(CMD_SEARCH, 30'd999999999, 3'd0, 32'h0, ans);
      send_item(CMD_SEARCH, 30'd1, 3'd0, 32'h0, ans);
      send_item(CMD_INSERT, 30'd536870912, 3'd5, 32'h8000_0000, ans);
      send_item(CMD_INSERT, 30'd1000000000, 3'd6, 32'h7FFF_FFFF, ans);
      send_item(CMD_SEARCH, 30'd1000000000, 3'd0, 32'h0, ans);
      send_item(CMD_SEARCH, 30'd0, 3'd0, 32'h0, ans);
   endtask

   // Mostly searches while the table slowly grows
   task automatic test_random_mix();
      table_answer_type ans;
      for (int i = 0; i < 1350; i++) begin
         if (i % 60 == 0)
            idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 99) < 15)
            send_item(CMD_INSERT, random_key(), GRADE_W'($urandom_range(0, 7)),
                      $urandom, ans);
         else
            send_item(CMD_SEARCH, search_key(), GRADE_W'($urandom_range(0, 7)),
                      $urandom, ans);
      end
   endtask

   // Insert until the probes run off the end, then fill from key zero's home slot to the end
   task automatic test_table_fill();
      table_answer_type ans;
      int               full_seen;
      int               guard;
      full_seen = 0;
      guard = 0;
      while (full_seen < 6 && guard < 800) begin
         if (guard % 60 == 0)
            idle_on = ($urandom_range(0, 3) != 0);
         send_item(CMD_INSERT, random_key(), GRADE_W'($urandom_range(0, 7)),
                   $urandom, ans);
         if (ans.status == ST_FULL)
            full_seen++;
         guard++;
      end
      guard = 0;
      do begin
         send_item(CMD_INSERT, 30'd0, GRADE_W'($urandom_range(0, 7)), $urandom, ans);
         guard++;
      end while (ans.status != ST_FULL && guard < 600);
      send_item(CMD_SEARCH, 30'd0, 3'd0, 32'h0, ans);
   endtask

   // Full table, no idling on either side
   task automatic test_full_table();
      table_answer_type ans;
      idle_on = 1'b0;
      for (int i = 0; i < 120; i++) begin
         if ($urandom_range(0, 9) < 3)
            send_item(CMD_INSERT, random_key(), GRADE_W'($urandom_range(0, 7)),
                      $urandom, ans);
         else
            send_item(CMD_SEARCH, search_key(), GRADE_W'($urandom_range(0, 7)),
                      $urandom, ans);
      end
   endtask

   // Result check and receiver stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (answers_due.size() == 0) begin
            report_mismatch("result with no item pending", 64'(rsp_status), 64'(0));
         end else begin
            due = answers_due.pop_front();
            if (rsp_status !== due.status)
               report_mismatch("status", 64'(rsp_status), 64'(due.status));
            if (rsp_slot !== due.slot)
               report_mismatch("slot", 64'(rsp_slot), 64'(due.slot));
            if (rsp_found_id !== due.id)
               report_mismatch("found_id", 64'(rsp_found_id), 64'(due.id));
            if (rsp_found_grade !== due.grade)
               report_mismatch("found_grade", 64'(rsp_found_grade), 64'(due.grade));
            if (rsp_found_handle !== due.handle)
               report_mismatch("found_handle", 64'(rsp_found_handle), 64'(due.handle));
            if (rsp_entry_count !== due.count)
               report_mismatch("entry_count", 64'(rsp_entry_count), 64'(due.count));
         end
      end
      if (idle_on && stall_left == 0 && $urandom_range(0, 9) == 0)
         stall_left = $urandom_range(1, 12);
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      int wait_cycles;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      wait_for_answers();
      test_random_mix();
      wait_for_answers();
      test_table_fill();
      test_full_table();
      // drain, then watch for stray results
      req_valid <= 1'b0;
      wait_cycles = 0;
      while (answers_due.size() != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (1300) @(posedge clock);
      if (answers_due.size() != 0)
         report_mismatch("answers never delivered", 64'(answers_due.size()), 64'(0));
      $display("covered %0d stores, %0d table-full inserts, %0d hits, %0d misses",
               status_tally[ST_INSERTED], status_tally[ST_FULL],
               status_tally[ST_FOUND], status_tally[ST_NOT_FOUND]);
      $display("%0d slots occupied at the end, %0d results checked, %0d mismatches",
               shadow_count, results_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Watchdog
   initial begin
      #250_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/lpht_pkg.sv
rtl/core/lpht_store.sv
rtl/core/lpht_hash.sv
rtl/core/linear_probe_hash_table_unit.sv
verif/testbench.sv
